// ===== rtl/mcc_pkg.sv =====
// Shared types and constants for the matrix chain cost evaluator.
// Holds symbol codes, status codes, sequencer states and arithmetic unit controls.
// No dependencies.
package mcc_pkg;

  localparam int unsigned DEF_STACK_DEPTH = 16;
  localparam int unsigned DEF_DIM_BITS    = 12;
  localparam int unsigned DEF_COST_BITS   = 48;

  localparam logic [7:0] SYM_CLOSE   = 8'h29;
  localparam logic [7:0] SYM_NEWLINE = 8'h0A;
  localparam logic [7:0] SYM_UPPER_A = 8'h41;
  localparam logic [7:0] SYM_UPPER_Z = 8'h5A;
  localparam logic [7:0] SYM_LOWER_A = 8'h61;
  localparam logic [7:0] SYM_LOWER_Z = 8'h7A;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNDERFLOW = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_MUL1,
    S_MUL2,
    S_ADD,
    S_WB,
    S_NL_OUT
  } state_e;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_DIMS,
    MUL_CHAIN
  } mul_op_e;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_COSTS,
    ADD_PROD
  } add_op_e;

  typedef struct packed {
    mul_op_e mul_op;
    add_op_e add_op;
  } arith_ctrl_t;

  function automatic logic is_letter(input logic [7:0] sym);
    return ((sym >= SYM_UPPER_A) && (sym <= SYM_UPPER_Z)) ||
           ((sym >= SYM_LOWER_A) && (sym <= SYM_LOWER_Z));
  endfunction

endpackage

// ===== rtl/mcc_if.sv =====
// Valid/ready channel interfaces for the matrix chain cost evaluator.
// Depends on mcc_pkg for default widths.
interface mcc_in_if
  import mcc_pkg::*;
#(
  parameter int unsigned DIM_BITS = DEF_DIM_BITS
);
  logic                valid;
  logic                ready;
  logic [7:0]          symbol;
  logic [DIM_BITS-1:0] rows;
  logic [DIM_BITS-1:0] cols;

  modport source (output valid, output symbol, output rows, output cols, input ready);
  modport sink   (input valid, input symbol, input rows, input cols, output ready);
endinterface

interface mcc_out_if
  import mcc_pkg::*;
#(
  parameter int unsigned DIM_BITS  = DEF_DIM_BITS,
  parameter int unsigned COST_BITS = DEF_COST_BITS
);
  logic                 valid;
  logic                 ready;
  logic [COST_BITS-1:0] total_cost;
  logic [DIM_BITS-1:0]  result_rows;
  logic [DIM_BITS-1:0]  result_cols;
  logic [1:0]           status;

  modport source (output valid, output total_cost, output result_rows, output result_cols,
                  output status, input ready);
  modport sink   (input valid, input total_cost, input result_rows, input result_cols,
                  input status, output ready);
endinterface

// ===== rtl/mcc_arith.sv =====
// Shared multiplier and saturating adder for the matrix chain cost evaluator.
// Depends on mcc_pkg for the control struct and operation codes.
module mcc_arith
  import mcc_pkg::*;
#(
  parameter int unsigned DIM_BITS  = DEF_DIM_BITS,
  parameter int unsigned COST_BITS = DEF_COST_BITS
) (
  input  logic                 clk_i,
  input  arith_ctrl_t          ctrl_i,
  input  logic [DIM_BITS-1:0]  a_rows_i,
  input  logic [DIM_BITS-1:0]  a_cols_i,
  input  logic [DIM_BITS-1:0]  b_cols_i,
  input  logic [COST_BITS-1:0] a_cost_i,
  input  logic [COST_BITS-1:0] b_cost_i,
  output logic [COST_BITS-1:0] cost_o
);

  localparam int unsigned PAIR_W = 2 * DIM_BITS;
  localparam int unsigned PROD_W = 3 * DIM_BITS;
  localparam int unsigned WIDE_W = (PROD_W > COST_BITS) ? PROD_W : COST_BITS;

  logic [PAIR_W-1:0]    mul_a;
  logic [DIM_BITS-1:0]  mul_b;
  logic [PROD_W-1:0]    mul_p;
  logic [PROD_W-1:0]    mul_q;
  logic [WIDE_W-1:0]    prod_wide;
  logic [COST_BITS-1:0] prod_sat;
  logic [COST_BITS-1:0] add_x;
  logic [COST_BITS-1:0] add_y;
  logic [COST_BITS:0]   add_s;
  logic [COST_BITS-1:0] add_sat;
  logic [COST_BITS-1:0] sum_q;

  // Operand select: first pass forms rows*inner, second pass scales by cols.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctrl_i.mul_op)
      MUL_DIMS: begin
        mul_a = PAIR_W'(a_rows_i);
        mul_b = a_cols_i;
      end
      MUL_CHAIN: begin
        mul_a = mul_q[PAIR_W-1:0];
        mul_b = b_cols_i;
      end
      default: ;
    endcase
  end

  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Clamp the product to the cost range.
  assign prod_wide = WIDE_W'(mul_q);
  assign prod_sat  = (prod_wide > WIDE_W'({COST_BITS{1'b1}})) ? {COST_BITS{1'b1}}
                                                               : COST_BITS'(prod_wide);

  always_comb begin
    add_x = '0;
    add_y = '0;
    unique case (ctrl_i.add_op)
      ADD_COSTS: begin
        add_x = a_cost_i;
        add_y = b_cost_i;
      end
      ADD_PROD: begin
        add_x = sum_q;
        add_y = prod_sat;
      end
      default: ;
    endcase
  end

  assign add_s   = {1'b0, add_x} + {1'b0, add_y};
  assign add_sat = add_s[COST_BITS] ? {COST_BITS{1'b1}} : add_s[COST_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_op != MUL_NONE) begin
      mul_q <= mul_p;
    end
    if (ctrl_i.add_op != ADD_NONE) begin
      sum_q <= add_sat;
    end
  end

  assign cost_o = sum_q;

endmodule

// ===== rtl/matrix_chain_cost_evaluator.sv =====
// Matrix chain cost evaluator: top level with operand stack and sequencer.
// Depends on mcc_pkg, the mcc_in_if / mcc_out_if interfaces and mcc_arith.
//
// Usage:
//   item_i carries one expression character per transaction (symbol, rows, cols).
//   A letter pushes its matrix with cost zero, ')' combines the two top entries,
//   a newline emits one result transaction on result_o and clears the stack.
//   Any other character, '(' included, is dropped.
// Sequencing:
//   Letters, ignored characters and ')' with too few entries stay in idle.
//   A combining ')' runs two stack reads through the single read port, two
//   passes through the shared multiplier, two saturating adds and one write
//   back. A newline runs a top read and a result load, and appears on
//   result_o the cycle after it is loaded.
// Stall:
//   The result sits in an output register; input transactions keep flowing
//   while it waits. A second newline holds in its result state until the
//   output register is free.
// Reset:
//   rst_ni clears the sequencer, the stack depth, the error record and the
//   output valid. Stack entries are not cleared; they are read only after
//   being written.
module matrix_chain_cost_evaluator
  import mcc_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = DEF_STACK_DEPTH,
  parameter int unsigned DIM_BITS    = DEF_DIM_BITS,
  parameter int unsigned COST_BITS   = DEF_COST_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mcc_in_if.sink    item_i,
  mcc_out_if.source result_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned EW = 2 * DIM_BITS + COST_BITS;

  // Entry layout: rows | cols | cost
  localparam int unsigned ROWS_LSB = DIM_BITS + COST_BITS;
  localparam int unsigned COLS_LSB = COST_BITS;

  state_e  state_q, state_d;
  logic [DW-1:0] depth_q, depth_d;
  status_e err_q, err_d;
  status_e res_st_q, res_st_d;
  logic    out_valid_q, out_valid_d;
  logic    out_load;

  logic [COST_BITS-1:0] out_cost_q;
  logic [DIM_BITS-1:0]  out_rows_q;
  logic [DIM_BITS-1:0]  out_cols_q;
  status_e              out_status_q;

  logic [EW-1:0] mem [STACK_DEPTH];
  logic [EW-1:0] rd_data_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;

  logic [DIM_BITS-1:0]  b_cols_q;
  logic [COST_BITS-1:0] b_cost_q;

  logic [DIM_BITS-1:0]  rd_rows;
  logic [DIM_BITS-1:0]  rd_cols;
  logic [COST_BITS-1:0] rd_cost;
  logic [COST_BITS-1:0] new_cost;

  logic [AW-1:0] top_idx;
  logic [AW-1:0] next_idx;
  logic [AW-1:0] below_idx;
  logic          in_fire;
  logic          stack_full;

  arith_ctrl_t arith_ctrl;

  assign in_fire    = item_i.valid && item_i.ready;
  assign top_idx    = AW'(depth_q - DW'(1));
  assign below_idx  = AW'(depth_q - DW'(2));
  assign next_idx   = AW'(depth_q);
  assign stack_full = (depth_q == DW'(STACK_DEPTH));

  assign rd_rows = rd_data_q[ROWS_LSB +: DIM_BITS];
  assign rd_cols = rd_data_q[COLS_LSB +: DIM_BITS];
  assign rd_cost = rd_data_q[COST_BITS-1:0];

  assign item_i.ready = (state_q == S_IDLE);

  // Sequencer: next state, stack access and arithmetic controls.
  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    err_d       = err_q;
    res_st_d    = res_st_q;
    out_valid_d = out_valid_q && !result_o.ready;
    out_load    = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = top_idx;
    wr_en       = 1'b0;
    wr_addr     = next_idx;
    wr_data     = {item_i.rows, item_i.cols, {COST_BITS{1'b0}}};
    arith_ctrl  = '{mul_op: MUL_NONE, add_op: ADD_NONE};

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (item_i.symbol == SYM_NEWLINE) begin
            // Pick the status now; clear the stack for the next expression.
            if (err_q != ST_OK) begin
              res_st_d = err_q;
            end else if (depth_q == '0) begin
              res_st_d = ST_EMPTY;
            end else begin
              res_st_d = ST_OK;
              rd_en    = 1'b1;
            end
            depth_d = '0;
            err_d   = ST_OK;
            state_d = S_NL_OUT;
          end else if (item_i.symbol == SYM_CLOSE) begin
            if (depth_q < DW'(2)) begin
              if (err_q == ST_OK) begin
                err_d = ST_UNDERFLOW;
              end
            end else begin
              rd_en   = 1'b1;
              state_d = S_RD_A;
            end
          end else if (is_letter(item_i.symbol)) begin
            if (stack_full) begin
              if (err_q == ST_OK) begin
                err_d = ST_OVERFLOW;
              end
            end else begin
              wr_en   = 1'b1;
              depth_d = depth_q + DW'(1);
            end
          end
        end
      end
      S_RD_A: begin
        // Top entry (B) is on the read port; fetch the one below it (A).
        rd_en   = 1'b1;
        rd_addr = below_idx;
        state_d = S_MUL1;
      end
      S_MUL1: begin
        arith_ctrl = '{mul_op: MUL_DIMS, add_op: ADD_COSTS};
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        arith_ctrl = '{mul_op: MUL_CHAIN, add_op: ADD_NONE};
        state_d    = S_ADD;
      end
      S_ADD: begin
        arith_ctrl = '{mul_op: MUL_NONE, add_op: ADD_PROD};
        state_d    = S_WB;
      end
      S_WB: begin
        // Replace A with the combined entry and drop B.
        wr_en   = 1'b1;
        wr_addr = below_idx;
        wr_data = {rd_rows, b_cols_q, new_cost};
        depth_d = depth_q - DW'(1);
        state_d = S_IDLE;
      end
      S_NL_OUT: begin
        // Hold until the output register is free.
        if (!out_valid_q || result_o.ready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      depth_q     <= '0;
      err_q       <= ST_OK;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      err_q       <= err_d;
      res_st_q    <= res_st_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_RD_A) begin
      b_cols_q <= rd_cols;
      b_cost_q <= rd_cost;
    end
    if (out_load) begin
      out_status_q <= res_st_q;
      if (res_st_q == ST_OK) begin
        out_cost_q <= rd_cost;
        out_rows_q <= rd_rows;
        out_cols_q <= rd_cols;
      end else begin
        out_cost_q <= '0;
        out_rows_q <= '0;
        out_cols_q <= '0;
      end
    end
  end

  mcc_arith #(
    .DIM_BITS  (DIM_BITS),
    .COST_BITS (COST_BITS)
  ) u_arith (
    .clk_i    (clk_i),
    .ctrl_i   (arith_ctrl),
    .a_rows_i (rd_rows),
    .a_cols_i (rd_cols),
    .b_cols_i (b_cols_q),
    .a_cost_i (rd_cost),
    .b_cost_i (b_cost_q),
    .cost_o   (new_cost)
  );

  assign result_o.valid       = out_valid_q;
  assign result_o.total_cost  = out_cost_q;
  assign result_o.result_rows = out_rows_q;
  assign result_o.result_cols = out_cols_q;
  assign result_o.status      = out_status_q;

`ifndef SYNTH
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DW'(STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_combine_pops_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && item_i.symbol == SYM_CLOSE && depth_q >= DW'(2))
      |-> ##6 (depth_q == $past(depth_q, 6) - DW'(1)))
    else $error("combine did not drop exactly one entry");

  a_newline_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && item_i.symbol == SYM_NEWLINE)
      |=> (depth_q == '0 && err_q == ST_OK && state_q == S_NL_OUT))
    else $error("newline did not clear the stack");

  a_wb_has_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB) |-> (depth_q >= DW'(2)))
    else $error("write back with fewer than two entries");

  a_error_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_status_q != ST_OK)
      |-> (out_cost_q == '0 && out_rows_q == '0 && out_cols_q == '0))
    else $error("error result carries a nonzero payload");
`endif

endmodule

// ===== verif/matrix_chain_cost_evaluator_tb.sv =====
// Self-checking testbench for matrix_chain_cost_evaluator: random character streams in,
// expression results checked against a cycle-free stack predictor.
// Depends on mcc_pkg, mcc_in_if / mcc_out_if and the evaluator RTL.
module matrix_chain_cost_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcc_pkg::*;

  localparam int unsigned STACK_N = DEF_STACK_DEPTH;
  localparam int unsigned DIM_W   = DEF_DIM_BITS;
  localparam int unsigned COST_W  = DEF_COST_BITS;
  localparam int unsigned DIM_MAX = (1 << DIM_W) - 1;
  localparam logic [COST_W-1:0] COST_MAX = '1;

  // '(' is only filler for the block, but it keeps the streams looking like real input.
  localparam logic [7:0] SYM_OPEN = 8'h28;

  localparam int unsigned RAND_ITEMS  = 2000;    // random letters, ')' and newlines
  localparam int unsigned CALM_ITEMS  = 200;     // no idling once this few items remain
  localparam int unsigned DRAIN_WAIT  = 20;      // settle time after the last result
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    logic [7:0]       sym;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
    bit               drain;   // hold this item until every pending result is out
  } char_item_t;

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [DIM_W-1:0]  rows;
    logic [DIM_W-1:0]  cols;
    status_e           status;
  } chain_result_t;

  logic clk;
  logic rst_n;

  mcc_in_if  #(.DIM_BITS(DIM_W))                     item_if ();
  mcc_out_if #(.DIM_BITS(DIM_W), .COST_BITS(COST_W)) res_if ();

  matrix_chain_cost_evaluator #(
    .STACK_DEPTH(STACK_N),
    .DIM_BITS   (DIM_W),
    .COST_BITS  (COST_W)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .item_i  (item_if.sink),
    .result_o(res_if.source)
  );

  // Stimulus waiting to be driven, and results waiting to be seen.
  char_item_t    pending_q[$];
  chain_result_t result_q[$];
  int unsigned   live_items;    // letters, ')' and newlines queued so far

  // Predictor copy of the operand stack.
  logic [DIM_W-1:0]  stk_rows [STACK_N];
  logic [DIM_W-1:0]  stk_cols [STACK_N];
  logic [COST_W-1:0] stk_cost [STACK_N];
  int unsigned       stk_depth;
  status_e           expr_err;   // ST_OK while the current expression is clean

  logic        item_taken;
  int unsigned src_gap, snk_gap;
  int unsigned src_idle_pct, snk_idle_pct;
  int unsigned mismatches;
  int unsigned cycle_count;

  function automatic bit is_alpha(logic [7:0] s);
    return s inside {[SYM_UPPER_A:SYM_UPPER_Z], [SYM_LOWER_A:SYM_LOWER_Z]};
  endfunction

  // Advance the predicted stack by one accepted character; queue a result on newline.
  function automatic void track_symbol(logic [7:0] sym, logic [DIM_W-1:0] r,
                                       logic [DIM_W-1:0] c);
    chain_result_t       res;
    logic [3*DIM_W-1:0]  prod;
    logic [COST_W+1:0]   sum;
    int unsigned         a, b;
    if (sym == SYM_NEWLINE) begin
      res = '0;
      if (expr_err != ST_OK) begin
        res.status = expr_err;
      end else if (stk_depth == 0) begin
        res.status = ST_EMPTY;
      end else begin
        // Only the top entry is reported, even with several left on the stack.
        res.cost   = stk_cost[stk_depth-1];
        res.rows   = stk_rows[stk_depth-1];
        res.cols   = stk_cols[stk_depth-1];
        res.status = ST_OK;
      end
      result_q.push_back(res);
      stk_depth = 0;
      expr_err  = ST_OK;
    end else if (sym == SYM_CLOSE) begin
      if (stk_depth < 2) begin
        if (expr_err == ST_OK) expr_err = ST_UNDERFLOW;
      end else begin
        a    = stk_depth - 2;
        b    = stk_depth - 1;
        prod = stk_rows[a] * stk_cols[a] * stk_cols[b];
        sum  = {2'b00, stk_cost[a]} + stk_cost[b] + prod;
        stk_cost[a] = (sum > COST_MAX) ? COST_MAX : sum[COST_W-1:0];
        stk_cols[a] = stk_cols[b];
        stk_depth   = stk_depth - 1;
      end
    end else if (is_alpha(sym)) begin
      if (stk_depth == STACK_N) begin
        if (expr_err == ST_OK) expr_err = ST_OVERFLOW;
      end else begin
        stk_rows[stk_depth] = r;
        stk_cols[stk_depth] = c;
        stk_cost[stk_depth] = '0;
        stk_depth = stk_depth + 1;
      end
    end
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(2))
      0:       return 0;
      1:       return 15;
      default: return 50;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus builders
  // ---------------------------------------------------------------------------
  function automatic void queue_char(int unsigned sym, int unsigned r, int unsigned c);
    char_item_t it;
    it.sym   = 8'(sym);
    it.rows  = DIM_W'(r);
    it.cols  = DIM_W'(c);
    it.drain = 1'b0;
    pending_q.push_back(it);
    if (it.sym == SYM_NEWLINE || it.sym == SYM_CLOSE || is_alpha(it.sym)) live_items++;
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(1)) return 8'(SYM_UPPER_A + $urandom_range(25));
    return 8'(SYM_LOWER_A + $urandom_range(25));
  endfunction

  // Lean toward the corners of the dimension range.
  function automatic int unsigned rand_dim();
    case ($urandom_range(9))
      0:       return 1;
      1:       return DIM_MAX;
      2:       return $urandom_range(16, 1);
      default: return $urandom_range(DIM_MAX, 1);
    endcase
  endfunction

  // Any byte the block drops: '(' half the time, otherwise a random non-code byte.
  function automatic logic [7:0] rand_filler();
    logic [7:0] s;
    if ($urandom_range(1)) return SYM_OPEN;
    do s = 8'($urandom_range(255));
    while (is_alpha(s) || s == SYM_CLOSE || s == SYM_NEWLINE);
    return s;
  endfunction

  // Well-formed expression with the given number of leaves; keep_open entries beyond the
  // top one stay uncombined. More than STACK_N leaves with push_first overflows the stack.
  function automatic void queue_expression(int unsigned leaves, int unsigned keep_open,
                                           bit push_first);
    int unsigned depth, pushed, closes, need;
    depth  = 0;
    pushed = 0;
    closes = 0;
    need   = (leaves > keep_open) ? leaves - 1 - keep_open : 0;
    while (pushed < leaves || closes < need) begin
      if ($urandom_range(5) == 0) queue_char(rand_filler(), rand_dim(), rand_dim());
      if (pushed < leaves &&
          (push_first || depth < 2 || closes >= need || (depth < STACK_N && $urandom_range(1))))
      begin
        queue_char(rand_letter(), rand_dim(), rand_dim());
        depth++;
        pushed++;
      end else begin
        queue_char(SYM_CLOSE, $urandom_range(DIM_MAX, 1), $urandom_range(DIM_MAX, 1));
        depth--;
        closes++;
      end
    end
    queue_char(SYM_NEWLINE, $urandom_range(DIM_MAX, 1), $urandom_range(DIM_MAX, 1));
  endfunction

  // Short run heavy in ')' so that the stack runs dry.
  function automatic void queue_broken();
    int unsigned n, k;
    n = $urandom_range(8, 1);
    for (k = 0; k < n; k++) begin
      case ($urandom_range(3))
        0:       queue_char(rand_letter(), rand_dim(), rand_dim());
        3:       queue_char(rand_filler(), rand_dim(), rand_dim());
        default: queue_char(SYM_CLOSE, rand_dim(), rand_dim());
      endcase
    end
    queue_char(SYM_NEWLINE, rand_dim(), rand_dim());
  endfunction

  // Raw bytes with raw fields; a newline may come up anywhere inside.
  function automatic void queue_noise();
    int unsigned n, k;
    n = $urandom_range(10, 1);
    for (k = 0; k < n; k++)
      queue_char($urandom_range(255), $urandom_range(DIM_MAX, 1), $urandom_range(DIM_MAX, 1));
    queue_char(SYM_NEWLINE, rand_dim(), rand_dim());
  endfunction

  // ---------------------------------------------------------------------------
  // Clock
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Monitor: check results and track accepted items, both on the rising edge.
  // Results are checked before the predictor runs; an expression's result can never
  // come out on the edge its newline goes in, so the order only keeps things tidy.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    chain_result_t want;
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result, got cost %0d rows %0d cols %0d status %0d",
                   $time, res_if.total_cost, res_if.result_rows, res_if.result_cols,
                   res_if.status);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("total_cost",  want.cost,   res_if.total_cost);
          check_field("result_rows", want.rows,   res_if.result_rows);
          check_field("result_cols", want.cols,   res_if.result_cols);
          check_field("status",      want.status, res_if.status);
        end
      end
      if (item_if.valid && item_if.ready)
        track_symbol(item_if.symbol, item_if.rows, item_if.cols);
    end
    item_taken <= rst_n && item_if.valid && item_if.ready;
  end

  // ---------------------------------------------------------------------------
  // Driver: present the next pending item on the falling edge once the previous
  // transaction has gone through. Idle in short bursts, except near the end. An item
  // flagged for drain holds back until every pending result has been collected.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    char_item_t nxt;
    if (rst_n) begin
      if (!item_if.valid || item_taken) begin
        if (src_gap != 0) begin
          src_gap--;
          item_if.valid <= 1'b0;
        end else if (pending_q.size() == 0 ||
                     (pending_q[0].drain && result_q.size() != 0)) begin
          item_if.valid <= 1'b0;
        end else if (pending_q.size() >= CALM_ITEMS &&
                     $urandom_range(99) < src_idle_pct) begin
          src_gap = $urandom_range(3);
          item_if.valid <= 1'b0;
        end else begin
          nxt = pending_q.pop_front();
          item_if.valid  <= 1'b1;
          item_if.symbol <= nxt.sym;
          item_if.rows   <= nxt.rows;
          item_if.cols   <= nxt.cols;
          if ($urandom_range(199) == 0) src_idle_pct = pick_idle_pct();
        end
      end
    end
  end

  // Result side: drop ready in random bursts, with calm stretches in between.
  always @(negedge clk) begin
    if (rst_n) begin
      if ($urandom_range(299) == 0) snk_idle_pct = pick_idle_pct();
      if (snk_gap != 0) begin
        snk_gap--;
        res_if.ready <= 1'b0;
      end else if (pending_q.size() >= CALM_ITEMS && $urandom_range(99) < snk_idle_pct) begin
        snk_gap = $urandom_range(3);
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               result_q.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned pick, idx, rand_start;
    bit          first;

    rst_n          = 1'b0;
    item_if.valid  = 1'b0;
    item_if.symbol = '0;
    item_if.rows   = '0;
    item_if.cols   = '0;
    res_if.ready   = 1'b0;
    item_taken     = 1'b0;
    stk_depth      = 0;
    expr_err       = ST_OK;
    src_gap        = 0;
    snk_gap        = 0;
    src_idle_pct   = 15;
    snk_idle_pct   = 15;
    mismatches     = 0;
    cycle_count    = 0;
    live_items     = 0;

    // Directed: empty expression, single letter at max size, smallest and largest
    // products, underflow, and two entries left with boundary filler bytes around
    // the letter ranges.
    queue_char(SYM_NEWLINE, 1, 1);
    queue_char(SYM_UPPER_A, DIM_MAX, DIM_MAX);
    queue_char(SYM_NEWLINE, 1, 1);
    queue_char(SYM_OPEN, DIM_MAX, DIM_MAX);
    queue_char(SYM_LOWER_A, 1, DIM_MAX);
    queue_char(SYM_LOWER_Z, DIM_MAX, 1);
    queue_char(SYM_CLOSE, 1, 1);
    queue_char(SYM_NEWLINE, DIM_MAX, DIM_MAX);
    queue_char(SYM_UPPER_Z, DIM_MAX, DIM_MAX);
    queue_char(SYM_UPPER_A + 12, DIM_MAX, DIM_MAX);
    queue_char(SYM_CLOSE, DIM_MAX, DIM_MAX);
    queue_char(SYM_NEWLINE, 1, 1);
    queue_char(SYM_UPPER_A + 1, 7, 9);
    queue_char(SYM_CLOSE, 3, 3);
    queue_char(SYM_UPPER_A + 2, 2, 2);
    queue_char(SYM_NEWLINE, 1, 1);
    queue_char(SYM_UPPER_Z - 1, 3, 5);
    queue_char(8'h00, 1, 1);
    queue_char(SYM_UPPER_A - 1, DIM_MAX, DIM_MAX);
    queue_char(SYM_UPPER_Z + 1, 1, 1);
    queue_char(SYM_LOWER_A - 1, DIM_MAX, DIM_MAX);
    queue_char(SYM_LOWER_Z + 1, 1, 1);
    queue_char(8'hFF, DIM_MAX, DIM_MAX);
    queue_char(SYM_LOWER_A + 1, 5, 2);
    queue_char(SYM_NEWLINE, 1, 1);

    // Random: mostly well-formed expressions, plus broken ones and noise.
    rand_start = live_items;
    first      = 1'b1;
    while (live_items - rand_start < RAND_ITEMS) begin
      idx  = pending_q.size();
      pick = $urandom_range(99);
      if (pick < 55)
        queue_expression($urandom_range(6), ($urandom_range(9) == 0) ? $urandom_range(3, 1) : 0,
                         $urandom_range(3) == 0);
      else if (pick < 67)
        queue_expression($urandom_range(STACK_N, 12),
                         ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 0,
                         $urandom_range(1));
      else if (pick < 74)
        queue_expression($urandom_range(STACK_N + 4, STACK_N + 1), 0, 1'b1);
      else if (pick < 88)
        queue_broken();
      else
        queue_noise();
      if (first || $urandom_range(32) == 0) pending_q[idx].drain = 1'b1;
      first = 1'b0;
    end

    // Reset once, released on a falling edge so the driver starts cleanly.
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in, every result to come out, then let the block settle.
    while (pending_q.size() != 0 || item_if.valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
